// File: rtl/rgb_to_hsl_assert.svh
// assertion macros for the checker file of rgb_to_hsl
// depends on clk and rst_n being visible where a macro is used
`ifndef RGB_TO_HSL_ASSERT_SVH
`define RGB_TO_HSL_ASSERT_SVH

// same-cycle implication, off during reset
`define RHSL_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rgb_to_hsl check failed");

// next-cycle implication, off during reset
`define RHSL_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rgb_to_hsl check failed");

`endif

// File: rtl/rhsl_pkg.sv
// shared widths, defaults and item types for rgb_to_hsl
// no dependencies
package rhsl_pkg;
    localparam int CH_W      = 8;
    localparam int FRAC_W    = 16;
    localparam int HUE_W     = FRAC_W + 1;
    localparam int SAT_W     = FRAC_W + 1;
    localparam int LIGHT_W   = CH_W + 1;
    localparam int HDIV_W    = CH_W + 3;
    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 2;

    // item handed from the front to the back
    typedef struct packed {
        logic [HDIV_W-1:0]  hnum;
        logic [HDIV_W-1:0]  hden;
        logic [CH_W-1:0]    vm;
        logic [CH_W-1:0]    sden;
        logic               zero;
        logic [LIGHT_W-1:0] light;
    } mid_item_t;

    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        logic [SAT_W-1:0]   sat;
        logic [LIGHT_W-1:0] light;
    } result_t;
endpackage

// File: rtl/rhsl_fifo.sv
// small register queue with push/full and pop/empty sides
// no package dependency
module rhsl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end
endmodule

// File: rtl/rhsl_front.sv
// front part: finds max/min, lightness and the operands of the hue and saturation divisions
// depends on rhsl_pkg
module rhsl_front (
    input  logic [rhsl_pkg::CH_W-1:0] red,
    input  logic [rhsl_pkg::CH_W-1:0] green,
    input  logic [rhsl_pkg::CH_W-1:0] blue,
    output rhsl_pkg::mid_item_t       item
);
    import rhsl_pkg::*;

    logic [CH_W-1:0]    v, m, vm;
    logic [LIGHT_W-1:0] sum;
    logic [HDIV_W-1:0]  vm_x, x3, x5, dr, dg, db;

    always_comb
    begin
        v = red;
        m = red;
        if (green > v) v = green;
        if (blue > v)  v = blue;
        if (green < m) m = green;
        if (blue < m)  m = blue;
        vm  = v - m;
        sum = {1'b0, v} + {1'b0, m};
        vm_x = HDIV_W'(vm);
        x3   = (vm_x << 1) + vm_x;
        x5   = (vm_x << 2) + vm_x;
        dr   = HDIV_W'(v - red);
        dg   = HDIV_W'(v - green);
        db   = HDIV_W'(v - blue);

        // sector numerator, ties go to the earlier test
        priority if (red == v)
        begin
            item.hnum = (green == m) ? x5 + db : vm_x - dg;
        end
        else if (green == v)
        begin
            item.hnum = (blue == m) ? vm_x + dr : x3 - db;
        end
        else
        begin
            item.hnum = (red == m) ? x3 + dg : x5 - dr;
        end

        item.hden  = x3 << 1;
        item.vm    = vm;
        item.sden  = (sum <= LIGHT_W'(255)) ? sum[CH_W-1:0]
                                            : CH_W'(LIGHT_W'(510) - sum);
        item.zero  = (sum == '0) || (vm == '0);
        item.light = sum;
    end
endmodule

// File: rtl/rhsl_div.sv
// pipelined restoring divider, one quotient bit per stage
// quotient of (num << (QW-1)) / den for num <= den; no package dependency
module rhsl_div #(
    parameter int DW = 8,
    parameter int QW = 17
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);
    logic [DW-1:0] rem_reg [QW];
    logic [DW-1:0] d_reg   [QW];
    logic [QW-1:0] q_reg   [QW];

    // first stage takes the integer bit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= (num >= den) ? num - den : num;
            d_reg[0]   <= den;
            q_reg[0]   <= QW'(num >= den);
        end
    end

    for (genvar s = 1; s < QW; s++)
    begin : g_stage
        logic [DW:0] t;
        logic        ge;
        assign t  = {rem_reg[s-1], 1'b0};
        assign ge = (t >= {1'b0, d_reg[s-1]});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= ge ? DW'(t - {1'b0, d_reg[s-1]}) : DW'(t);
                d_reg[s]   <= d_reg[s-1];
                q_reg[s]   <= {q_reg[s-1][QW-2:0], ge};
            end
        end
    end

    assign quo = q_reg[QW-1];
endmodule

// File: rtl/rhsl_back.sv
// back part: pops classified items and runs the hue and saturation dividers
// depends on rhsl_pkg, rhsl_div
module rhsl_back (
    input  logic                clk,
    input  logic                rst_n,
    input  rhsl_pkg::mid_item_t mid_item,
    input  logic                mid_empty,
    output logic                mid_pop,
    output rhsl_pkg::result_t   res,
    output logic                res_push,
    input  logic                res_full
);
    import rhsl_pkg::*;

    localparam int LAT = HUE_W;

    logic [LAT-1:0]     vld_reg;
    logic               zero_reg  [LAT];
    logic [LIGHT_W-1:0] light_reg [LAT];
    logic               en;
    logic [HUE_W-1:0]   hq;
    logic [SAT_W-1:0]   sq;

    // whole pipe holds while its last item cannot leave
    assign en       = !(vld_reg[LAT-1] && res_full);
    assign mid_pop  = en && !mid_empty;
    assign res_push = vld_reg[LAT-1] && !res_full;

    rhsl_div #(.DW(HDIV_W), .QW(HUE_W)) u_hdiv (
        .clk (clk), .en (en), .num (mid_item.hnum), .den (mid_item.hden), .quo (hq)
    );

    rhsl_div #(.DW(CH_W), .QW(SAT_W)) u_sdiv (
        .clk (clk), .en (en), .num (mid_item.vm), .den (mid_item.sden), .quo (sq)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], !mid_empty};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0]  <= mid_item.zero;
            light_reg[0] <= mid_item.light;
            for (int s = 1; s < LAT; s++)
            begin
                zero_reg[s]  <= zero_reg[s-1];
                light_reg[s] <= light_reg[s-1];
            end
        end
    end

    assign res.hue   = zero_reg[LAT-1] ? '0 : hq;
    assign res.sat   = zero_reg[LAT-1] ? '0 : sq;
    assign res.light = light_reg[LAT-1];
endmodule

// File: rtl/rgb_to_hsl.sv
// rgb_to_hsl: converts 8-bit rgb pixels to hue, saturation (1.16 fractions,
// truncated, 65536 = 1.0) and lightness (v+m out of 510). one item is taken
// per clock and one result leaves per clock when pop keeps up; the figure is
// set by the two 17-stage dividers, which each retire one item per cycle
// unless a full result queue stalls them. an accepted item is taken by the
// back from the middle queue, passes the 17 divider stages in order, and is
// then written into the result queue, whose head is on the result ports.
// grey and black pixels give hue 0 and saturation 0; pure red gives hue 65536.
// depends on rhsl_pkg, rhsl_fifo, rhsl_front, rhsl_back
module rgb_to_hsl #(
    parameter int MID_DEPTH = rhsl_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = rhsl_pkg::OUT_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [rhsl_pkg::CH_W-1:0]    red,
    input  logic [rhsl_pkg::CH_W-1:0]    green,
    input  logic [rhsl_pkg::CH_W-1:0]    blue,
    output logic                         empty,
    input  logic                         pop,
    output logic [rhsl_pkg::HUE_W-1:0]   hue,
    output logic [rhsl_pkg::SAT_W-1:0]   saturation,
    output logic [rhsl_pkg::LIGHT_W-1:0] lightness
);
    import rhsl_pkg::*;

    mid_item_t front_item, mid_item;
    result_t   back_res, out_res;
    logic      mid_empty, mid_pop;
    logic      res_push, res_full;

    // front: combinational classification straight into the middle queue
    rhsl_front u_front (
        .red (red), .green (green), .blue (blue), .item (front_item)
    );

    // middle queue decouples input acceptance from divider stalls
    rhsl_fifo #(.WIDTH($bits(mid_item_t)), .DEPTH(MID_DEPTH)) u_mid_q (
        .clk (clk), .rst_n (rst_n),
        .push (push), .wdata (front_item), .full (full),
        .pop (mid_pop), .rdata (mid_item), .empty (mid_empty)
    );

    // back: divider pipeline, stalls as a whole when results back up
    rhsl_back u_back (
        .clk (clk), .rst_n (rst_n),
        .mid_item (mid_item), .mid_empty (mid_empty), .mid_pop (mid_pop),
        .res (back_res), .res_push (res_push), .res_full (res_full)
    );

    // result queue, head item is on the output ports
    rhsl_fifo #(.WIDTH($bits(result_t)), .DEPTH(OUT_DEPTH)) u_out_q (
        .clk (clk), .rst_n (rst_n),
        .push (res_push), .wdata (back_res), .full (res_full),
        .pop (pop), .rdata (out_res), .empty (empty)
    );

    assign hue        = out_res.hue;
    assign saturation = out_res.sat;
    assign lightness  = out_res.light;
endmodule

// File: rtl/rhsl_checker.sv
// port-level checks for rgb_to_hsl, bound onto the top level
// depends on rhsl_pkg and rgb_to_hsl_assert.svh
`include "rgb_to_hsl_assert.svh"

module rhsl_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         empty,
    input logic                         pop,
    input logic [rhsl_pkg::HUE_W-1:0]   hue,
    input logic [rhsl_pkg::SAT_W-1:0]   saturation,
    input logic [rhsl_pkg::LIGHT_W-1:0] lightness
);
    import rhsl_pkg::*;

    // fractions never exceed one full unit
    `RHSL_ASSERT_NOW(a_hue_range, !empty, hue <= HUE_W'(65536))
    `RHSL_ASSERT_NOW(a_sat_range, !empty, saturation <= SAT_W'(65536))
    // an achromatic pixel carries no hue
    `RHSL_ASSERT_NOW(a_grey_hue, !empty && saturation == '0, hue == '0)
    // a nonzero saturation needs a nonzero lightness
    `RHSL_ASSERT_NOW(a_sat_light, !empty && saturation != '0, lightness != '0)
    // a waiting result stays until popped
    `RHSL_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(hue)
                      && $stable(saturation) && $stable(lightness))
endmodule

bind rgb_to_hsl rhsl_checker u_rhsl_checker (
    .clk (clk), .rst_n (rst_n), .empty (empty),
    .pop (pop), .hue (hue), .saturation (saturation), .lightness (lightness)
);

// File: tb/rgb_to_hsl_test.sv
// testbench for rgb_to_hsl: drives rgb pixel items, predicts hue, saturation
// and lightness in integer math, and checks each result in order
// depends on rhsl_pkg and the rgb_to_hsl rtl
`timescale 1ns / 1ps

module rgb_to_hsl_test;
    import rhsl_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } pixel_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
    logic               empty;
    logic               pop;
    logic [HUE_W-1:0]   hue;
    logic [SAT_W-1:0]   saturation;
    logic [LIGHT_W-1:0] lightness;

    pixel_t  pixel_q[$];     // pixels waiting to be offered
    result_t hsl_q[$];       // predicted hsl values, oldest first
    int      errors;
    int      send_idle_pct;  // chance in a hundred that the sender idles
    int      recv_idle_pct;  // chance in a hundred that the receiver stalls
    int      hold_cycles;    // receiver hold-off, counted down per cycle
    bit      send_pause;     // sender holds back while set

    rgb_to_hsl u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .empty      (empty),
        .pop        (pop),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // integer hsl conversion, ties in the hue sector go to the first test
    function automatic result_t predict_hsl(pixel_t p);
        result_t res;
        int unsigned v;
        int unsigned m;
        int unsigned vm;
        int unsigned sum;
        int unsigned den;
        int unsigned num;
        longint unsigned h;
        longint unsigned s;
        v = p.r;
        m = p.r;
        if (p.g > v) v = p.g;
        if (p.b > v) v = p.b;
        if (p.g < m) m = p.g;
        if (p.b < m) m = p.b;
        sum = v + m;
        vm = v - m;
        h = 0;
        s = 0;
        // black and grey pixels keep hue and saturation at zero
        if (sum != 0 && vm != 0)
        begin
            den = (sum <= 255) ? sum : 510 - sum;
            s = (longint'(vm) * 65536) / den;
            if (p.r == v)
                num = (p.g == m) ? 5 * vm + (v - p.b) : vm - (v - p.g);
            else if (p.g == v)
                num = (p.b == m) ? vm + (v - p.r) : 3 * vm - (v - p.b);
            else
                num = (p.r == m) ? 3 * vm + (v - p.g) : 5 * vm - (v - p.r);
            h = (longint'(num) * 65536) / (6 * longint'(vm));
        end
        res.hue = h[HUE_W-1:0];
        res.sat = s[SAT_W-1:0];
        res.light = sum[LIGHT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // driver: keeps push high across back-to-back items, one assignment per edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            red <= '0;
            green <= '0;
            blue <= '0;
        end
        else
        begin
            automatic bit taken = push && !full;
            automatic bit busy = push && !taken;
            if (taken)
                hsl_q.push_back(predict_hsl('{red, green, blue}));
            if (!busy)
            begin
                if (pixel_q.size() > 0 && !send_pause
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    automatic pixel_t p = pixel_q.pop_front();
                    push <= 1'b1;
                    red <= p.r;
                    green <= p.g;
                    blue <= p.b;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each popped result with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (hsl_q.size() == 0)
                begin
                    $display("result with no pixel pending");
                    errors++;
                end
                else
                begin
                    automatic result_t want = hsl_q.pop_front();
                    if (hue !== want.hue)
                        report_mismatch("hue", hue, want.hue);
                    if (saturation !== want.sat)
                        report_mismatch("saturation", saturation, want.sat);
                    if (lightness !== want.light)
                        report_mismatch("lightness", lightness, want.light);
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic add_pixel(int r, int g, int b);
        pixel_q.push_back('{r[7:0], g[7:0], b[7:0]});
    endtask

    // channels biased toward ties, extremes and narrow spreads
    function automatic logic [7:0] pick_channel(logic [7:0] base);
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd255;
            2: return base;
            3: return base + 8'($urandom_range(3));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic add_random(int count);
        for (int i = 0; i < count; i++)
        begin
            logic [7:0] base;
            base = 8'($urandom);
            add_pixel(pick_channel(base), pick_channel(base), pick_channel(base));
        end
    endtask

    // checked at the falling edge, once all clocked updates have settled
    task automatic drain();
        while (pixel_q.size() > 0 || push || hsl_q.size() > 0)
            @(negedge clk);
    endtask

    initial
    begin
        errors = 0;
        send_idle_pct = 8;
        recv_idle_pct = 64;
        hold_cycles = 0;
        send_pause = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: black, white, grey, primaries, secondaries, tie orders
        add_pixel(0, 0, 0);
        add_pixel(255, 255, 255);
        add_pixel(128, 128, 128);
        add_pixel(255, 0, 0);
        add_pixel(0, 255, 0);
        add_pixel(0, 0, 255);
        add_pixel(255, 255, 0);
        add_pixel(0, 255, 255);
        add_pixel(255, 0, 255);
        add_pixel(200, 100, 50);
        add_pixel(200, 50, 100);
        add_pixel(100, 200, 50);
        add_pixel(50, 200, 100);
        add_pixel(50, 100, 200);
        add_pixel(100, 50, 200);
        add_pixel(1, 0, 0);
        add_pixel(255, 254, 254);
        add_pixel(127, 128, 128);
        add_pixel(128, 127, 127);
        add_pixel(170, 85, 170);
        add_pixel(85, 170, 170);
        drain();

        add_random(250);
        // long receiver hold-off while the sender keeps offering
        @(posedge clk);
        hold_cycles <= 200;
        drain();

        send_idle_pct = 64;
        recv_idle_pct = 8;
        add_random(250);
        drain();

        // sender pauses mid-stream until every result is back, then resumes
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(250);
        repeat (60) @(negedge clk);
        send_pause = 1'b1;
        while (push || hsl_q.size() > 0)
            @(negedge clk);
        send_pause = 1'b0;
        drain();

        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("rgb_to_hsl_test: clean");
        else
            $display("rgb_to_hsl_test: errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("rgb_to_hsl_test: errors");
        $finish;
    end
endmodule

// File: rgb_to_hsl.f
+incdir+rtl
rtl/rhsl_pkg.sv
rtl/rhsl_fifo.sv
rtl/rhsl_front.sv
rtl/rhsl_div.sv
rtl/rhsl_back.sv
rtl/rgb_to_hsl.sv
rtl/rhsl_checker.sv
tb/rgb_to_hsl_test.sv
